/* design/les_pkg.sv */
// shared types and constants for the largest empty square finder
// no dependencies; used by scoped names by every module of the block but les_ram
`default_nettype none

package les_pkg;

  // default grid limits
  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS_DEF = 4096;

  // row width register
  localparam int CFG_W         = 11;
  localparam int ROW_WIDTH_RST = 1;

  // input stream payload: cell_empty in bit 0, padded to a byte
  localparam int IN_W = 8;

  // per-request control flags carried from the scan counters to the cell unit
  typedef struct packed {
    logic last;       // final cell of the grid
    logic first_row;  // row counter is zero
    logic first_col;  // column counter is zero
    logic row_end;    // this cell closes its row
  } les_tag_t;

endpackage

`default_nettype wire

/* design/les_ram.sv */
// generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module les_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* design/les_scan_ctrl.sv */
// column and row counters that place each accepted cell in the grid
// depends on les_pkg (tag struct, register width)
`default_nettype none

module les_scan_ctrl #(
  parameter int MAX_COLS = les_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = les_pkg::MAX_ROWS_DEF,
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     accept,
  input  wire logic                     last,
  input  wire logic [les_pkg::CFG_W-1:0] row_width,
  output logic      [CW-1:0]            col_index,
  output logic      [RW-1:0]            row_index,
  output les_pkg::les_tag_t             tag
);

  logic [CW-1:0] col_index_r, col_index_nxt;
  logic [RW-1:0] row_index_r, row_index_nxt;
  logic [31:0]   col_p1;
  logic [31:0]   width_lim;
  logic          row_end;

  // effective row width: zero acts as one, clamp to the line buffer depth
  always_comb begin
    if (row_width == '0) begin
      width_lim = 32'd1;
    end else if (32'(row_width) > 32'(MAX_COLS)) begin
      width_lim = 32'(MAX_COLS);
    end else begin
      width_lim = 32'(row_width);
    end
    col_p1  = 32'(col_index_r) + 32'd1;
    row_end = (col_p1 >= width_lim);
  end

  // counter advance on each accepted request
  always_comb begin
    col_index_nxt = col_index_r;
    row_index_nxt = row_index_r;
    if (accept) begin
      if (last) begin
        col_index_nxt = '0;
        row_index_nxt = '0;
      end else if (row_end) begin
        col_index_nxt = '0;
        if (32'(row_index_r) < 32'(MAX_ROWS - 1)) begin
          row_index_nxt = row_index_r + RW'(1);
        end
      end else begin
        col_index_nxt = col_p1[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_index_r <= '0;
      row_index_r <= '0;
    end else begin
      col_index_r <= col_index_nxt;
      row_index_r <= row_index_nxt;
    end
  end

  // flags for the cell now at the input
  always_comb begin
    tag.last      = last;
    tag.first_row = (row_index_r == '0);
    tag.first_col = (col_index_r == '0);
    tag.row_end   = row_end;
  end

  assign col_index = col_index_r;
  assign row_index = row_index_r;

endmodule

`default_nettype wire

/* design/les_cell_unit.sv */
// square size recurrence and running maximum, one cell per cycle unless stalled
// depends on les_pkg (tag struct); reads the line buffer data from les_ram
`default_nettype none

module les_cell_unit #(
  parameter int MAX_COLS = les_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = les_pkg::MAX_ROWS_DEF,
  localparam int SW = $clog2(MAX_COLS + 1),
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic              cell_empty,
  input  wire les_pkg::les_tag_t tag,
  input  wire logic [CW-1:0]     col_in,
  input  wire logic [RW-1:0]     row_in,
  input  wire logic              stall,
  input  wire logic [SW-1:0]     up_size,
  output logic                   busy_last,
  output logic      [CW-1:0]     cur_col,
  output logic                   buf_we,
  output logic      [SW-1:0]     buf_wdata,
  output logic                   res_valid,
  output logic      [SW-1:0]     res_size,
  output logic      [RW-1:0]     res_row,
  output logic      [CW-1:0]     res_col
);

  // stage register for the cell under work
  logic              s1_valid_r;
  logic              s1_empty_r;
  les_pkg::les_tag_t s1_tag_r;
  logic [CW-1:0]     s1_col_r;
  logic [RW-1:0]     s1_row_r;

  // scan state
  logic [SW-1:0] left_size_r, left_size_nxt;
  logic [SW-1:0] diag_size_r, diag_size_nxt;
  logic [SW-1:0] max_size_r,  max_size_nxt;
  logic [RW-1:0] max_row_r,   max_row_nxt;
  logic [CW-1:0] max_col_r,   max_col_nxt;

  logic          s1_fire;
  logic [SW-1:0] min_lu;
  logic [SW-1:0] min3;
  logic [SW-1:0] size;
  logic [SW-1:0] best_size;
  logic [RW-1:0] best_row;
  logic [CW-1:0] best_col;

  assign s1_fire = s1_valid_r && !stall;

  // stage load; hold while the result register is blocked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_empty_r <= cell_empty;
      s1_tag_r   <= tag;
      s1_col_r   <= col_in;
      s1_row_r   <= row_in;
    end
  end

  // size: obstacle 0, edge cell 1, else smallest neighbour plus one
  always_comb begin
    min_lu = (left_size_r < up_size) ? left_size_r : up_size;
    min3   = (min_lu < diag_size_r) ? min_lu : diag_size_r;
    if (!s1_empty_r) begin
      size = '0;
    end else if (s1_tag_r.first_row || s1_tag_r.first_col) begin
      size = SW'(1);
    end else begin
      size = min3 + SW'(1);
    end
  end

  // first maximum in scan order wins, so only a strictly larger size replaces it
  always_comb begin
    if (size > max_size_r) begin
      best_size = size;
      best_row  = s1_row_r;
      best_col  = s1_col_r;
    end else begin
      best_size = max_size_r;
      best_row  = max_row_r;
      best_col  = max_col_r;
    end
  end

  // scan state update
  always_comb begin
    left_size_nxt = left_size_r;
    diag_size_nxt = diag_size_r;
    max_size_nxt  = max_size_r;
    max_row_nxt   = max_row_r;
    max_col_nxt   = max_col_r;
    if (s1_fire) begin
      if (s1_tag_r.last) begin
        left_size_nxt = '0;
        diag_size_nxt = '0;
        max_size_nxt  = '0;
        max_row_nxt   = '0;
        max_col_nxt   = '0;
      end else begin
        max_size_nxt = best_size;
        max_row_nxt  = best_row;
        max_col_nxt  = best_col;
        if (s1_tag_r.row_end) begin
          left_size_nxt = '0;
          diag_size_nxt = '0;
        end else begin
          left_size_nxt = size;
          diag_size_nxt = up_size;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_size_r <= '0;
      diag_size_r <= '0;
      max_size_r  <= '0;
      max_row_r   <= '0;
      max_col_r   <= '0;
    end else begin
      left_size_r <= left_size_nxt;
      diag_size_r <= diag_size_nxt;
      max_size_r  <= max_size_nxt;
      max_row_r   <= max_row_nxt;
      max_col_r   <= max_col_nxt;
    end
  end

  // line buffer write-back and result
  assign buf_we    = s1_fire;
  assign buf_wdata = size;
  assign cur_col   = s1_col_r;
  assign busy_last = s1_valid_r && s1_tag_r.last;
  assign res_valid = s1_fire && s1_tag_r.last;
  assign res_size  = best_size;
  assign res_row   = best_row;
  assign res_col   = best_col;

endmodule

`default_nettype wire

/* design/largest_empty_square_finder_core.sv */
// top level of the largest empty square finder
// depends on les_pkg, les_ram, les_scan_ctrl and les_cell_unit
`default_nettype none

// Grid cells stream in row-major order, one empty/obstacle bit per request,
// with in_tlast on the final cell; cfg_wdata sets the row width (0 acts as 1,
// values above MAX_COLS act as MAX_COLS). The block accepts one cell every
// cycle unless stalled. The accepting edge places a cell in the stage register
// and issues the line buffer read; the edge that fires the stage, once no
// stall holds it, computes its square size from the left, up and up-left
// sizes and updates the running maximum. The line buffer is one RAM of MAX_COLS
// entries with one write and one registered read per cycle; it needs no
// clearing after reset. On the last cell one result request carries the
// largest square size and its bottom-right row and column (topmost, then
// leftmost, on a tie; size 0 at row 0, column 0 for an all-obstacle grid).
// Results pass through a two-entry buffer, so in_tready never depends on
// out_tready in the same cycle. Input stalls only while two finished results
// wait and the next last cell is held in the stage register.
module largest_empty_square_finder_core #(
  parameter int MAX_COLS = les_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = les_pkg::MAX_ROWS_DEF,
  localparam int SW    = $clog2(MAX_COLS + 1),
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int OUT_W = ((SW + RW + CW + 7) / 8) * 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [les_pkg::CFG_W-1:0] cfg_wdata,   // row_width
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [les_pkg::IN_W-1:0]  in_tdata,    // [0] cell_empty, rest zero
  input  wire logic                      in_tlast,    // last_cell
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic      [OUT_W-1:0]          out_tdata    // best_size, best_row, best_col
);

  logic [les_pkg::CFG_W-1:0] row_width_r;
  logic                      in_accept;
  logic                      stall;
  logic [CW-1:0]             col_index;
  logic [RW-1:0]             row_index;
  les_pkg::les_tag_t         tag;
  logic                      busy_last;
  logic [CW-1:0]             cur_col;
  logic                      buf_we;
  logic [SW-1:0]             buf_wdata;
  logic [SW-1:0]             up_size;
  logic [CW-1:0]             buf_raddr;
  logic                      res_valid;
  logic [SW-1:0]             res_size;
  logic [RW-1:0]             res_row;
  logic [CW-1:0]             res_col;
  logic [OUT_W-1:0]          res_data;
  logic                      out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]          out_data_r, out_data_nxt;
  logic                      skid_valid_r, skid_valid_nxt;
  logic [OUT_W-1:0]          skid_data_r, skid_data_nxt;

  // row width register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= les_pkg::CFG_W'(les_pkg::ROW_WIDTH_RST);
    end else if (cfg_we) begin
      row_width_r <= cfg_wdata;
    end
  end

  // input handshake: stall while a held last cell finds both result entries full
  assign stall     = busy_last && skid_valid_r;
  assign in_tready = !stall;
  assign in_accept = in_tvalid && in_tready;

  les_scan_ctrl #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .last      (in_tlast),
    .row_width (row_width_r),
    .col_index (col_index),
    .row_index (row_index),
    .tag       (tag)
  );

  // read ahead at the new cell's column; while held, re-read the held column
  assign buf_raddr = in_accept ? col_index : cur_col;

  les_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_COLS)
  ) u_line_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (cur_col),
    .wdata (buf_wdata),
    .raddr (buf_raddr),
    .rdata (up_size)
  );

  les_cell_unit #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_cell (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .cell_empty (in_tdata[0]),
    .tag        (tag),
    .col_in     (col_index),
    .row_in     (row_index),
    .stall      (stall),
    .up_size    (up_size),
    .busy_last  (busy_last),
    .cur_col    (cur_col),
    .buf_we     (buf_we),
    .buf_wdata  (buf_wdata),
    .res_valid  (res_valid),
    .res_size   (res_size),
    .res_row    (res_row),
    .res_col    (res_col)
  );

  assign res_data = OUT_W'({res_col, res_row, res_size});

  // two-entry result buffer: the head drives the port, the second entry
  // catches a result that finishes while the head is held
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
        out_data_nxt  = res_data;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

/* design/les_checker.sv */
// port-level checks for the largest empty square finder
// depends on les_pkg; bound to largest_empty_square_finder_core
`default_nettype none

module les_checker #(
  parameter int MAX_COLS = les_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = les_pkg::MAX_ROWS_DEF,
  localparam int SW    = $clog2(MAX_COLS + 1),
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int OUT_W = ((SW + RW + CW + 7) / 8) * 8
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic             in_tlast,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata
);

  logic [SW-1:0] chk_size;
  logic [RW-1:0] chk_row;
  logic [CW-1:0] chk_col;

  assign chk_size = out_tdata[SW-1:0];
  assign chk_row  = out_tdata[SW+RW-1:SW];
  assign chk_col  = out_tdata[SW+RW+CW-1:SW+RW];

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a new result follows an accepted last cell
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2))
    else $error("result without a last cell");

  // empty result reports the origin
  a_zero_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (chk_size == '0) |-> (chk_row == '0) && (chk_col == '0))
    else $error("size zero not at origin");

  // the square fits left of its corner
  a_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(chk_size) <= 32'(chk_col) + 32'd1)
    else $error("square wider than its column");

endmodule

bind largest_empty_square_finder_core les_checker #(
  .MAX_COLS (MAX_COLS),
  .MAX_ROWS (MAX_ROWS)
) u_les_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
